FILE: design/argb_linear_gradient_color_top_assert.svh
// ----------------------------------------------------------------------------
// Gradient assertion macros
// Shared concurrent checks on clk, quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef ARGB_LINEAR_GRADIENT_COLOR_TOP_ASSERT_SVH
`define ARGB_LINEAR_GRADIENT_COLOR_TOP_ASSERT_SVH

// same-cycle implication
`define LGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gradient check failed");

// next-cycle implication
`define LGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gradient check failed");

`endif

FILE: design/argb_lgc_pkg.sv
// ----------------------------------------------------------------------------
// argb_lgc_pkg
// Widths, register map, reset values and stage words of the gradient block.
// ----------------------------------------------------------------------------
package argb_lgc_pkg;

  localparam int POSITION_BITS = 12;
  localparam int SPAN_BITS     = 13;
  localparam int CMP_BITS      = (POSITION_BITS > SPAN_BITS) ? POSITION_BITS : SPAN_BITS;
  localparam int S_DATA_BITS   = ((POSITION_BITS + 7) / 8) * 8;
  localparam int COLOR_BITS    = 32;
  localparam int CHAN_BITS     = 8;
  localparam int COLOR_LANES   = 3;
  localparam int IDX_BITS      = 8;

  // divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = IDX_BITS / DIV_STEPS;

  // idx*100/255 as one constant multiply: idx * (100 * 32897) >> 23
  localparam int          PCT_PROD_BITS = 30;
  localparam int          PCT_BITS      = 7;
  localparam logic [21:0] PCT_MUL       = 22'd3289700;
  // t/100 for t <= 25500: t * 5243 >> 19
  localparam int          INC_PROD_BITS = 28;
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          INC_SHIFT     = 19;

  localparam logic [CHAN_BITS:0]   OPAQUE_SUM = 9'd510;
  localparam logic [CHAN_BITS-1:0] CHAN_MAX   = 8'hff;

  // register map
  localparam int          REG_ADDR_BITS    = 4;
  localparam logic [1:0]  REG_START_COLOR  = 2'd0;
  localparam logic [1:0]  REG_END_COLOR    = 2'd1;
  localparam logic [1:0]  REG_SPAN_LENGTH  = 2'd2;

  localparam logic [COLOR_BITS-1:0] START_COLOR_RST = 32'hff000000;
  localparam logic [COLOR_BITS-1:0] END_COLOR_RST   = 32'hffffffff;
  localparam logic [SPAN_BITS-1:0]  SPAN_LENGTH_RST = 13'd256;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic                beyond;
  } lgc_index_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] alpha;
    logic [CHAN_BITS-1:0] ws;
    logic [CHAN_BITS-1:0] we;
    logic                 beyond;
  } lgc_weight_t;

endpackage

FILE: design/argb_lgc_div.sv
// ----------------------------------------------------------------------------
// argb_lgc_div
// Pipelined restoring divider: index = (position * 256) / span, saturated.
// ----------------------------------------------------------------------------
module argb_lgc_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [argb_lgc_pkg::SPAN_BITS-1:0]     span,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [argb_lgc_pkg::POSITION_BITS-1:0] in_pos,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output argb_lgc_pkg::lgc_index_t               out_word
);

  localparam int STAGES = argb_lgc_pkg::DIV_STAGES + 1;
  localparam int LAST   = STAGES - 1;
  localparam int SB     = argb_lgc_pkg::SPAN_BITS;
  localparam int QB     = argb_lgc_pkg::IDX_BITS;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] rdy;
  logic [STAGES-1:0] bey;
  logic [STAGES-1:0] bey_next;
  logic [SB-1:0]     rem      [STAGES];
  logic [SB-1:0]     rem_next [STAGES];
  logic [QB-1:0]     quo      [STAGES];
  logic [QB-1:0]     quo_next [STAGES];

  logic [argb_lgc_pkg::CMP_BITS-1:0] pos_ext;
  logic [argb_lgc_pkg::CMP_BITS-1:0] span_ext;
  logic [SB-1:0] r;
  logic [SB:0]   r2;
  logic [QB-1:0] q;
  logic          take;

  always_comb begin
    rdy[LAST] = !vld[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    pos_ext  = argb_lgc_pkg::CMP_BITS'(in_pos);
    span_ext = argb_lgc_pkg::CMP_BITS'(span);
    bey_next[0] = (pos_ext >= span_ext);
    rem_next[0] = bey_next[0] ? '0 : pos_ext[SB-1:0];
    quo_next[0] = '0;
    r    = '0;
    r2   = '0;
    q    = '0;
    take = 1'b0;
    for (int i = 1; i < STAGES; i++) begin
      r = rem[i-1];
      q = quo[i-1];
      for (int k = 0; k < argb_lgc_pkg::DIV_STEPS; k++) begin
        r2   = {r, 1'b0};
        take = (r2 >= {1'b0, span});
        if (take) begin
          r2 = r2 - {1'b0, span};
        end
        r = r2[SB-1:0];
        q = {q[QB-2:0], take};
      end
      rem_next[i] = r;
      quo_next[i] = q;
      bey_next[i] = bey[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGES; i++) begin
      if (rdy[i]) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
        bey[i] <= bey_next[i];
      end
    end
  end

  assign out_valid       = vld[LAST];
  assign out_word.idx    = bey[LAST] ? argb_lgc_pkg::CHAN_MAX : quo[LAST];
  assign out_word.beyond = bey[LAST];

endmodule

FILE: design/argb_lgc_weight.sv
// ----------------------------------------------------------------------------
// argb_lgc_weight
// Turns the blend index into start and end weights and the result alpha.
// ----------------------------------------------------------------------------
module argb_lgc_weight (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [argb_lgc_pkg::CHAN_BITS-1:0]   start_alpha,
  input  logic [argb_lgc_pkg::CHAN_BITS-1:0]   end_alpha,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  argb_lgc_pkg::lgc_index_t             in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output argb_lgc_pkg::lgc_weight_t            out_word
);

  localparam int CB = argb_lgc_pkg::CHAN_BITS;
  localparam int PB = argb_lgc_pkg::PCT_BITS;

  logic [2:0] vld;
  logic [2:0] rdy;

  logic          opaque;
  logic [CB-1:0] mx;

  logic [argb_lgc_pkg::PCT_PROD_BITS-1:0] pct_prod;
  logic [argb_lgc_pkg::INC_PROD_BITS-1:0] inc_prod;
  logic [CB-1:0]                          inc;

  logic [argb_lgc_pkg::IDX_BITS-1:0] s1_idx;
  logic [PB-1:0]                     s1_pct;
  logic                              s1_bey;
  logic [argb_lgc_pkg::IDX_BITS-1:0] s2_idx;
  logic [PB+CB-1:0]                  s2_t;
  logic                              s2_bey;
  argb_lgc_pkg::lgc_weight_t         s3_word;
  argb_lgc_pkg::lgc_weight_t         s3_next;

  // alphas are configuration; the user must keep them stable while words are in flight (not enforced here)
  assign opaque = ({1'b0, start_alpha} + {1'b0, end_alpha}) == argb_lgc_pkg::OPAQUE_SUM;
  assign mx     = (end_alpha > start_alpha) ? end_alpha : start_alpha;

  assign rdy[2]   = !vld[2] || out_ready;
  assign rdy[1]   = !vld[1] || rdy[2];
  assign rdy[0]   = !vld[0] || rdy[1];
  assign in_ready = rdy[0];

  assign pct_prod = argb_lgc_pkg::PCT_PROD_BITS'(in_word.idx)
                  * argb_lgc_pkg::PCT_PROD_BITS'(argb_lgc_pkg::PCT_MUL);
  assign inc_prod = argb_lgc_pkg::INC_PROD_BITS'(s2_t)
                  * argb_lgc_pkg::INC_PROD_BITS'(argb_lgc_pkg::RECIP_100);
  assign inc      = inc_prod[argb_lgc_pkg::INC_SHIFT +: CB];

  always_comb begin
    s3_next.beyond = s2_bey;
    if (opaque) begin
      s3_next.alpha = argb_lgc_pkg::CHAN_MAX;
      s3_next.ws    = argb_lgc_pkg::CHAN_MAX - s2_idx;
      s3_next.we    = s2_idx;
    end else begin
      s3_next.alpha = mx;
      s3_next.ws    = mx - inc;
      s3_next.we    = inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_idx <= in_word.idx;
      s1_pct <= pct_prod[argb_lgc_pkg::PCT_PROD_BITS-1 -: PB];
      s1_bey <= in_word.beyond;
    end
    if (rdy[1]) begin
      s2_idx <= s1_idx;
      s2_t   <= (PB+CB)'(s1_pct) * (PB+CB)'(mx);
      s2_bey <= s1_bey;
    end
    if (rdy[2]) begin
      s3_word <= s3_next;
    end
  end

  assign out_valid = vld[2];
  assign out_word  = s3_word;

endmodule

FILE: design/argb_lgc_blend.sv
// ----------------------------------------------------------------------------
// argb_lgc_blend
// Weights the color channels, sums them and holds the result word.
// ----------------------------------------------------------------------------
module argb_lgc_blend (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [argb_lgc_pkg::COLOR_BITS-1:0]   start_color,
  input  logic [argb_lgc_pkg::COLOR_BITS-1:0]   end_color,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  argb_lgc_pkg::lgc_weight_t             in_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [argb_lgc_pkg::COLOR_BITS-1:0]   out_color,
  output logic                                  out_beyond
);

  localparam int CB    = argb_lgc_pkg::CHAN_BITS;
  localparam int LANES = argb_lgc_pkg::COLOR_LANES;

  logic [1:0] vld;
  logic [1:0] rdy;

  logic [2*CB-1:0] pa [LANES];
  logic [2*CB-1:0] pz [LANES];
  logic [CB-1:0]   b1_pa [LANES];
  logic [CB-1:0]   b1_pz [LANES];
  logic [CB-1:0]   b1_alpha;
  logic            b1_bey;

  logic [CB:0]                         lane_sum;
  logic [argb_lgc_pkg::COLOR_BITS-1:0] color_next;
  logic [argb_lgc_pkg::COLOR_BITS-1:0] color;
  logic                                bey;

  assign rdy[1]   = !vld[1] || out_ready;
  assign rdy[0]   = !vld[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      pa[c] = (2*CB)'(start_color[c*CB +: CB]) * (2*CB)'(in_word.ws);
      pz[c] = (2*CB)'(end_color[c*CB +: CB]) * (2*CB)'(in_word.we);
    end
  end

  always_comb begin
    lane_sum   = '0;
    color_next = '0;
    for (int c = 0; c < LANES; c++) begin
      lane_sum = {1'b0, b1_pa[c]} + {1'b0, b1_pz[c]};
      color_next[c*CB +: CB] = lane_sum[CB-1:0];
    end
    color_next[LANES*CB +: CB] = b1_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int c = 0; c < LANES; c++) begin
        b1_pa[c] <= pa[c][2*CB-1:CB];
        b1_pz[c] <= pz[c][2*CB-1:CB];
      end
      b1_alpha <= in_word.alpha;
      b1_bey   <= in_word.beyond;
    end
    if (rdy[1]) begin
      color <= color_next;
      bey   <= b1_bey;
    end
  end

  assign out_valid  = vld[1];
  assign out_color  = color;
  assign out_beyond = bey;

endmodule

FILE: design/argb_linear_gradient_color_top.sv
// ----------------------------------------------------------------------------
// argb_linear_gradient_color_top
// ARGB color of one line of a linear gradient between two configured colors.
//
//   Port group   Dir   Handshake          Payload
//   s_*          in    s_tvalid/s_tready  s_tdata: line_position
//   m_*          out   m_tvalid/m_tready  m_tdata: pixel_color, m_tuser: beyond_span
//   p*           in    APB, pready = 1    start_color, end_color, span_length
//
// One word per clock in and out while m_tready is high. A result word passes
// five divider stages, three weight stages and two blend stages before it shows
// on m_*. Every stage holds under back-pressure and takes a new word as soon as
// it empties. rst is synchronous: it empties the pipeline and reloads the
// registers to their defaults.
// ----------------------------------------------------------------------------
`include "argb_linear_gradient_color_top_assert.svh"

module argb_linear_gradient_color_top (
  input  logic                                      clk,
  input  logic                                      rst,
  // stream in
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [argb_lgc_pkg::S_DATA_BITS-1:0]      s_tdata,   // [11:0] line_position
  // stream out
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [argb_lgc_pkg::COLOR_BITS-1:0]       m_tdata,   // [31:0] pixel_color
  output logic [0:0]                                m_tuser,   // [0] beyond_span
  // configuration
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [argb_lgc_pkg::REG_ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                               pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam int CB = argb_lgc_pkg::CHAN_BITS;

  logic [argb_lgc_pkg::COLOR_BITS-1:0] start_color;
  logic [argb_lgc_pkg::COLOR_BITS-1:0] end_color;
  logic [argb_lgc_pkg::SPAN_BITS-1:0]  span_length;
  logic [1:0]                          reg_sel;

  logic                      idx_vld;
  logic                      idx_rdy;
  argb_lgc_pkg::lgc_index_t  idx_word;
  logic                      wgt_vld;
  logic                      wgt_rdy;
  argb_lgc_pkg::lgc_weight_t wgt_word;

  assign pready  = 1'b1;
  assign reg_sel = paddr[argb_lgc_pkg::REG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color <= argb_lgc_pkg::START_COLOR_RST;
      end_color   <= argb_lgc_pkg::END_COLOR_RST;
      span_length <= argb_lgc_pkg::SPAN_LENGTH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        argb_lgc_pkg::REG_START_COLOR: start_color <= pwdata;
        argb_lgc_pkg::REG_END_COLOR:   end_color   <= pwdata;
        argb_lgc_pkg::REG_SPAN_LENGTH: span_length <= pwdata[argb_lgc_pkg::SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      argb_lgc_pkg::REG_START_COLOR: prdata = start_color;
      argb_lgc_pkg::REG_END_COLOR:   prdata = end_color;
      argb_lgc_pkg::REG_SPAN_LENGTH: prdata = 32'(span_length);
      default:                       prdata = '0;
    endcase
  end

  argb_lgc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .span      (span_length),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pos    (s_tdata[argb_lgc_pkg::POSITION_BITS-1:0]),
    .out_valid (idx_vld),
    .out_ready (idx_rdy),
    .out_word  (idx_word)
  );

  argb_lgc_weight u_weight (
    .clk         (clk),
    .rst         (rst),
    .start_alpha (start_color[argb_lgc_pkg::COLOR_BITS-1 -: CB]),
    .end_alpha   (end_color[argb_lgc_pkg::COLOR_BITS-1 -: CB]),
    .in_valid    (idx_vld),
    .in_ready    (idx_rdy),
    .in_word     (idx_word),
    .out_valid   (wgt_vld),
    .out_ready   (wgt_rdy),
    .out_word    (wgt_word)
  );

  argb_lgc_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .start_color (start_color),
    .end_color   (end_color),
    .in_valid    (wgt_vld),
    .in_ready    (wgt_rdy),
    .in_word     (wgt_word),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_color   (m_tdata),
    .out_beyond  (m_tuser[0])
  );

  // a position past the span must leave the divider saturated
  `LGC_ASSERT_NOW(a_beyond_saturates, idx_vld && idx_word.beyond,
                  idx_word.idx == argb_lgc_pkg::CHAN_MAX)
  // weights always split the result alpha exactly
  `LGC_ASSERT_NOW(a_weight_split, wgt_vld,
                  (9'(wgt_word.ws) + 9'(wgt_word.we)) == 9'(wgt_word.alpha))
  // input back-pressure only comes from a stalled full output
  `LGC_ASSERT_NOW(a_stall_origin, !s_tready, m_tvalid && !m_tready)
  // two opaque end colors give an opaque result
  `LGC_ASSERT_NOW(a_opaque_alpha,
                  m_tvalid && start_color[31:24] == argb_lgc_pkg::CHAN_MAX
                  && end_color[31:24] == argb_lgc_pkg::CHAN_MAX,
                  m_tdata[31:24] == argb_lgc_pkg::CHAN_MAX)

endmodule
